@@ hdl/msh_pkg.sv @@
// shared types, widths and codes of the multichannel sample history
package msh_pkg;

    localparam int SAMPLE_W          = 10;
    localparam int CHANNEL_W         = 3;
    localparam int WANT_W            = 8;
    localparam int AGE_W             = 6;
    localparam int TOTAL_W           = 7;
    localparam int CMD_W             = 2;
    localparam int MASK_W            = 4;
    localparam int MAX_CHANNELS      = 4;
    localparam int MAX_RESULTS       = 32;
    localparam int RUN_W             = $clog2(MAX_RESULTS + 1);
    localparam int DATA_W            = 32;
    localparam int ADDR_W            = 3;

    localparam int HISTORY_DEPTH_DEF = 32;
    localparam int CHANNEL_COUNT_DEF = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_CAPTURE     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ_LATEST = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ_LAST_N = 2'd2;

    // register index of the channel mask, taken from paddr[2]
    localparam logic REG_CHANNEL_MASK = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]     cmd;
        logic [CHANNEL_W-1:0] channel;
        logic [WANT_W-1:0]    count_wanted;
        logic [SAMPLE_W-1:0]  sample_ch0;
        logic [SAMPLE_W-1:0]  sample_ch1;
        logic [SAMPLE_W-1:0]  sample_ch2;
        logic [SAMPLE_W-1:0]  sample_ch3;
    } req_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample_value;
        logic [AGE_W-1:0]    age_index;
        logic [TOTAL_W-1:0]  delivered_total;
        logic                empty_answer;
        logic                last_of_run;
    } rsp_t;

endpackage

@@ hdl/msh_store.sv @@
// banked sample memory, one bank per channel, registered read port
module msh_store
    import msh_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF,
    parameter int HW            = $clog2(HISTORY_DEPTH),
    parameter int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1
)
(
    input  logic                                   clk,
    input  logic [CHANNEL_COUNT-1:0]               wr_en,
    input  logic [CHANNEL_COUNT-1:0][HW-1:0]       wr_addr,
    input  logic [CHANNEL_COUNT-1:0][SAMPLE_W-1:0] wr_data,
    input  logic                                   rd_en,
    input  logic [CH_W-1:0]                        rd_ch,
    input  logic [HW-1:0]                          rd_addr,
    output logic [SAMPLE_W-1:0]                    rd_data
);

    logic [SAMPLE_W-1:0] mem [CHANNEL_COUNT][HISTORY_DEPTH];

    // every bank takes its own write in the same cycle
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_bank
        always_ff @(posedge clk)
        begin
            if (wr_en[c])
            begin
                mem[c][wr_addr[c]] <= wr_data[c];
            end
        end
    end

    // read data holds while rd_en is low
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_ch][rd_addr];
        end
    end

endmodule

@@ hdl/multichannel_sample_history.sv @@
// per-channel circular sample history with capture, read latest and read last n
// capture: the request port is free again on the next cycle
// read: the request loads the sequencer, then each memory read passes stage 1 and the
//   output register, one result per cycle (output stalls permitting); a read of n results
//   holds the request port until all its reads are issued, set by the single memory read port
// reset clears heads, fill counts, mask and handshake state; the sample memory is not cleared
module multichannel_sample_history
    import msh_pkg::*;
#(
    parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
    parameter int CHANNEL_COUNT = CHANNEL_COUNT_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    // request channel
    input  logic              req_valid,
    output logic              req_stall,
    input  req_t              req_data,
    // result channel
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output rsp_t              rsp_data,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int HW     = $clog2(HISTORY_DEPTH);
    localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CH_W   = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    // sequencer codes
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    // configuration
    logic [MASK_W-1:0] mask_reg;
    logic              cfg_wr;

    // per-channel pointers, small enough to live in flops
    logic [CHANNEL_COUNT-1:0][HW-1:0]     head_reg,  head_next;
    logic [CHANNEL_COUNT-1:0][FILL_W-1:0] fill_reg,  fill_next;

    // read sequencer
    logic                state_reg, state_next;
    logic [RUN_W-1:0]    left_reg,  left_next;
    logic [AGE_W-1:0]    age_reg,   age_next;
    logic [HW-1:0]       ptr_reg,   ptr_next;
    logic [CH_W-1:0]     ch_reg,    ch_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic                empty_reg, empty_next;

    // stage between memory read and output register
    logic                s1_valid_reg;
    logic [AGE_W-1:0]    s1_age_reg;
    logic [TOTAL_W-1:0]  s1_total_reg;
    logic                s1_empty_reg;
    logic                s1_last_reg;

    // output register
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;

    // handshake and memory signals
    logic                                   req_take;
    logic                                   capture;
    logic                                   out_free;
    logic                                   s1_move;
    logic                                   s1_free;
    logic                                   issue;
    logic [CHANNEL_COUNT-1:0]               wr_en;
    logic [CHANNEL_COUNT-1:0][HW-1:0]       wr_addr;
    logic [CHANNEL_COUNT-1:0][SAMPLE_W-1:0] wr_data;
    logic                                   rd_en;
    logic [SAMPLE_W-1:0]                    rd_data;
    logic [MAX_CHANNELS-1:0][SAMPLE_W-1:0]  samples;

    // read setup for the requested channel
    logic [FILL_W-1:0]   sel_fill;
    logic [HW-1:0]       sel_head;
    logic                ch_ok;
    logic [RUN_W-1:0]    want_cap;
    logic [RUN_W-1:0]    run_len;
    logic                run_empty;

    // ------------------------------------------------------------------
    // configuration port: zero wait states, mask register at offset 0
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_wr && (paddr[2] == REG_CHANNEL_MASK))
        begin
            mask_reg <= pwdata[MASK_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_CHANNEL_MASK) ? DATA_W'(mask_reg) : '0;

    // ------------------------------------------------------------------
    // request side: a read run blocks further requests until all its
    // memory reads are issued, so a capture never meets a pending read
    // ------------------------------------------------------------------
    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign capture   = req_take && (req_data.cmd == CMD_CAPTURE);

    assign samples = {req_data.sample_ch3, req_data.sample_ch2,
                      req_data.sample_ch1, req_data.sample_ch0};

    // capture: every enabled channel writes its own bank at its head
    always_comb
    begin
        wr_en     = '0;
        wr_addr   = '0;
        wr_data   = '0;
        head_next = head_reg;
        fill_next = fill_reg;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            wr_addr[c] = head_reg[c];
            wr_data[c] = samples[c];
            if (capture && mask_reg[c])
            begin
                wr_en[c]     = 1'b1;
                head_next[c] = (head_reg[c] == HW'(HISTORY_DEPTH - 1)) ?
                               '0 : head_reg[c] + HW'(1);
                // fill count saturates at the history depth
                if (fill_reg[c] != FILL_W'(HISTORY_DEPTH))
                begin
                    fill_next[c] = fill_reg[c] + FILL_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            fill_reg <= fill_next;
        end
    end

    // pick head and fill count of the requested channel
    always_comb
    begin
        sel_fill = '0;
        sel_head = '0;
        for (int c = 0; c < CHANNEL_COUNT; c++)
        begin
            if (req_data.channel == CHANNEL_W'(c))
            begin
                sel_fill = fill_reg[c];
                sel_head = head_reg[c];
            end
        end
    end

    assign ch_ok = (req_data.channel < CHANNEL_W'(CHANNEL_COUNT));

    // run length: count wanted clamped to the per-command limit and the fill count
    always_comb
    begin
        want_cap = (req_data.count_wanted > WANT_W'(MAX_RESULTS)) ?
                   RUN_W'(MAX_RESULTS) : req_data.count_wanted[RUN_W-1:0];
        run_empty = !ch_ok || (sel_fill == '0) ||
                    ((req_data.cmd == CMD_READ_LAST_N) && (req_data.count_wanted == '0));
        if (req_data.cmd == CMD_READ_LATEST)
        begin
            run_len = RUN_W'(1);
        end
        else if (WANT_W'(sel_fill) < WANT_W'(want_cap))
        begin
            run_len = RUN_W'(sel_fill);
        end
        else
        begin
            run_len = want_cap;
        end
    end

    // ------------------------------------------------------------------
    // read sequencer: one memory read per cycle while stage 1 has room,
    // walking backward from the newest slot; an empty answer is a run
    // of one that skips the memory
    // ------------------------------------------------------------------
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign s1_move  = s1_valid_reg && out_free;
    assign s1_free  = !s1_valid_reg || s1_move;
    assign issue    = (state_reg == ST_RUN) && s1_free;
    assign rd_en    = issue && !empty_reg;

    always_comb
    begin
        state_next = state_reg;
        left_next  = left_reg;
        age_next   = age_reg;
        ptr_next   = ptr_reg;
        ch_next    = ch_reg;
        total_next = total_reg;
        empty_next = empty_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    case (req_data.cmd) inside
                        CMD_READ_LATEST, CMD_READ_LAST_N:
                        begin
                            state_next = ST_RUN;
                            left_next  = run_empty ? RUN_W'(1) : run_len;
                            total_next = run_empty ? '0 : TOTAL_W'(run_len);
                            empty_next = run_empty;
                            age_next   = '0;
                            ch_next    = req_data.channel[CH_W-1:0];
                            // newest sample sits one slot behind the head
                            ptr_next   = (sel_head == '0) ?
                                         HW'(HISTORY_DEPTH - 1) : sel_head - HW'(1);
                        end
                        default:
                        begin
                            // capture is handled above, the unused code does nothing
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (issue)
                begin
                    left_next = left_reg - RUN_W'(1);
                    age_next  = age_reg + AGE_W'(1);
                    ptr_next  = (ptr_reg == '0) ? HW'(HISTORY_DEPTH - 1) : ptr_reg - HW'(1);
                    if (left_reg == RUN_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        age_reg   <= age_next;
        ptr_reg   <= ptr_next;
        ch_reg    <= ch_next;
        total_reg <= total_next;
        empty_reg <= empty_next;
    end

    msh_store #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .HW            (HW),
        .CH_W          (CH_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_ch   (ch_reg),
        .rd_addr (ptr_reg),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // stage 1 tags the memory read data; it only loads when it is free,
    // so the held read data always belongs to it
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (issue)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s1_age_reg   <= age_reg;
            s1_total_reg <= total_reg;
            s1_empty_reg <= empty_reg;
            s1_last_reg  <= (left_reg == RUN_W'(1));
        end
    end

    // output register: parts the result channel from the memory pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_move)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            rsp_reg.sample_value    <= s1_empty_reg ? '0 : rd_data;
            rsp_reg.age_index       <= s1_age_reg;
            rsp_reg.delivered_total <= s1_total_reg;
            rsp_reg.empty_answer    <= s1_empty_reg;
            rsp_reg.last_of_run     <= s1_last_reg;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

`ifndef SYNTH
    // stage 1 is never overwritten while its result is still waiting
    a_s1_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |-> !issue)
        else $error("stage 1 overwritten while held");

    // issuing the final read of a run returns the sequencer to idle
    a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (issue && (left_reg == RUN_W'(1))) |=> (state_reg == ST_IDLE))
        else $error("read run did not end after its last read");

    // an empty answer is always a single, final result with nothing delivered
    a_empty_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_reg.empty_answer) |->
        (rsp_reg.last_of_run && (rsp_reg.delivered_total == '0)))
        else $error("malformed empty answer");

    // fill counts never pass the history depth
    for (genvar c = 0; c < CHANNEL_COUNT; c++) begin : g_fill_chk
        a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
            capture |=> (fill_reg[c] <= FILL_W'(HISTORY_DEPTH)))
            else $error("fill count above history depth");
    end
`endif

endmodule
